### design/kmot_pkg.sv
// kmot_pkg: payload structs, status codes and controller/datapath interface
// types for the keyed minimum occupancy table. No dependencies.
`timescale 1ns / 1ps

package kmot_pkg;

  localparam int ID_BITS  = 16;
  localparam int POS_BITS = 20;

  localparam logic       OP_ENTER = 1'b0;
  localparam logic       OP_LEAVE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [ID_BITS-1:0]  vehicle_id;
    logic [POS_BITS-1:0] back_position;
  } in_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0] last_free_position;
    logic [1:0]          status;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic issue_last;
    logic out_ready;
  } dp_status_t;

endpackage

### design/keyed_min_occupancy_table.sv
// Keyed minimum occupancy table, top level: joins controller and datapath.
// Depends on kmot_pkg, kmot_ctrl, kmot_datapath.
//
// Each accepted item (enter/update or leave, keyed by vehicle_id) yields one
// result: the smallest of stop_end_position and every stored rear position,
// plus a status (ok, table full, id not found). The result is set by a scan
// that reads one slot per cycle from the key/position memories, then a drain
// and a commit that waits for the output register; the next item is accepted
// the cycle after the result is written to the output register, even while
// that result still waits on out_stall.
// The valid bits clear at reset, so no clearing pass runs.
`timescale 1ns / 1ps

module keyed_min_occupancy_table #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  kmot_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output kmot_pkg::out_item_t           out_item,
  input  logic                          cfg_wr_en,
  input  logic [kmot_pkg::POS_BITS-1:0] cfg_wr_data
);

  kmot_pkg::ctl_cmd_t   cmd;
  kmot_pkg::dp_status_t sts;

  kmot_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kmot_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

  a_commit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_ready)
    else $error("commit while result register is blocked");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.start && cmd.issue) && !(cmd.start && cmd.commit) && !(cmd.issue && cmd.commit))
    else $error("overlapping controller commands");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status != 2'd3))
    else $error("illegal status code");

endmodule

### design/kmot_ctrl.sv
// kmot_ctrl: sequencer for one item: accept, slot scan, drain, commit.
// Depends on kmot_pkg.
`timescale 1ns / 1ps

module kmot_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kmot_pkg::dp_status_t sts,
  output kmot_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/kmot_datapath.sv
// kmot_datapath: slot key/position memories, valid bits, scan and minimum
// logic, stop end register and result register. Depends on kmot_pkg.
`timescale 1ns / 1ps

module kmot_datapath #(
  parameter int SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kmot_pkg::in_item_t              in_item,
  input  logic                            cfg_wr_en,
  input  logic [kmot_pkg::POS_BITS-1:0]   cfg_wr_data,
  input  kmot_pkg::ctl_cmd_t              cmd,
  output kmot_pkg::dp_status_t            sts,
  input  logic                            out_stall,
  output logic                            out_valid,
  output kmot_pkg::out_item_t             out_item
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [kmot_pkg::ID_BITS-1:0]  key_mem [SLOTS];
  logic [kmot_pkg::POS_BITS-1:0] pos_mem [SLOTS];
  logic [SLOTS-1:0]              slot_valid_r;

  logic [kmot_pkg::POS_BITS-1:0] stop_end_r;
  kmot_pkg::in_item_t            item_r;
  logic [IDX_W-1:0]              idx_r;

  logic                          rd_en_r;
  logic                          rd_vld_r;
  logic [IDX_W-1:0]              rd_idx_r;
  logic [kmot_pkg::ID_BITS-1:0]  rd_key_r;
  logic [kmot_pkg::POS_BITS-1:0] rd_pos_r;

  logic [kmot_pkg::POS_BITS-1:0] min_r;
  logic                          match_r;
  logic [IDX_W-1:0]              match_idx_r;
  logic                          free_r;
  logic [IDX_W-1:0]              free_idx_r;

  logic                          out_valid_r, out_valid_nxt;
  kmot_pkg::out_item_t           out_item_r, out_item_nxt;

  logic                          hit;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_idx;
  logic                          clr_en;
  logic [kmot_pkg::POS_BITS-1:0] min_with_new;

  assign sts.issue_last = (idx_r == IDX_W'(SLOTS - 1));
  assign sts.out_ready  = !out_valid_r || !out_stall;

  assign hit = rd_en_r && rd_vld_r && (rd_key_r == item_r.vehicle_id);

  assign min_with_new = (item_r.back_position < min_r) ? item_r.back_position : min_r;

  always_comb begin
    wr_en        = 1'b0;
    wr_idx       = match_idx_r;
    clr_en       = 1'b0;
    out_item_nxt = out_item_r;
    if (cmd.commit) begin
      out_item_nxt.status             = kmot_pkg::ST_OK;
      out_item_nxt.last_free_position = min_r;
      if (item_r.operation == kmot_pkg::OP_ENTER) begin
        if (match_r || free_r) begin
          wr_en                           = 1'b1;
          wr_idx                          = match_r ? match_idx_r : free_idx_r;
          out_item_nxt.last_free_position = min_with_new;
        end else begin
          out_item_nxt.status = kmot_pkg::ST_FULL;
        end
      end else begin
        if (match_r) begin
          clr_en = 1'b1;
        end else begin
          out_item_nxt.status = kmot_pkg::ST_UNKNOWN;
        end
      end
    end
  end

  assign out_valid_nxt = cmd.commit || (out_valid_r && out_stall);

  // memories: one read port on the scan index, one write port at commit
  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[idx_r];
    rd_pos_r <= pos_mem[idx_r];
    rd_idx_r <= idx_r;
    rd_vld_r <= slot_valid_r[idx_r];
    if (wr_en) begin
      key_mem[wr_idx] <= item_r.vehicle_id;
      pos_mem[wr_idx] <= item_r.back_position;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      stop_end_r   <= '0;
      idx_r        <= '0;
      rd_en_r      <= 1'b0;
      min_r        <= '0;
      match_r      <= 1'b0;
      match_idx_r  <= '0;
      free_r       <= 1'b0;
      free_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rd_en_r     <= cmd.issue;
      if (cfg_wr_en) begin
        stop_end_r <= cfg_wr_data;
      end
      if (cmd.start) begin
        idx_r   <= '0;
        min_r   <= stop_end_r;
        match_r <= 1'b0;
        free_r  <= 1'b0;
      end else begin
        if (cmd.issue) begin
          idx_r <= idx_r + IDX_W'(1);
        end
        // matched slot is left out of the minimum; for an enter its new value is added at commit
        if (hit) begin
          match_r     <= 1'b1;
          match_idx_r <= rd_idx_r;
        end else if (rd_en_r && rd_vld_r && (rd_pos_r < min_r)) begin
          min_r <= rd_pos_r;
        end
        if (rd_en_r && !rd_vld_r && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= rd_idx_r;
        end
      end
      if (wr_en) begin
        slot_valid_r[wr_idx] <= 1'b1;
      end
      if (clr_en) begin
        slot_valid_r[match_idx_r] <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
